// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared constants, codes and structs of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned POOL_DEPTH  = 64;
  localparam int unsigned SLOT_W      = $clog2(POOL_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned ITEM_W      = 13;
  localparam int unsigned CFG_COUNT_W = 7;
  localparam int unsigned SIZE_W      = ITEM_W + 1;
  localparam int unsigned PROD_W      = SLOT_W + SIZE_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned ITEM_RESET  = 4;

  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_FREE       = 2'd1,
    REQ_ADDR_OF_IX = 2'd2,
    REQ_IX_OF_ADDR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NONE_FREE     = 3'd1,
    ST_NULL          = 3'd2,
    ST_BELOW_BASE    = 3'd3,
    ST_MISALIGNED    = 3'd4,
    ST_BEYOND_END    = 3'd5,
    ST_NOT_ALLOCATED = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_ITEM_SIZE  = 2'd1,
    CFG_POOL_COUNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    req_e              req_type;
    logic [ADDR_W-1:0] address;
    logic [IDX_W-1:0]  index;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] block_address;
    logic [IDX_W-1:0]  block_index;
  } rsp_t;

  // effective pool geometry
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_res_t;

endpackage

// ===== rtl/fbpa_if.sv =====
// ----------------------------------------------------------------------------
// fbpa channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface fbpa_req_if;
  import fbpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ADDR_W-1:0]    address;
  logic [IDX_W-1:0]     index;

  modport source (output valid, req_type, address, index, input ready);
  modport sink (input valid, req_type, address, index, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [ADDR_W-1:0]    block_address;
  logic [IDX_W-1:0]     block_index;

  modport source (output valid, status, block_address, block_index, input ready);
  modport sink (input valid, status, block_address, block_index, output ready);
endinterface

interface fbpa_cfg_if;
  import fbpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// fixed-size block pool: allocate, free and slot/address lookups
// ----------------------------------------------------------------------------
//
//   channel | dir | beat carries
//   --------+-----+--------------------------------------------------
//   req     | in  | req_type, address, index
//   rsp     | out | status, block_address, block_index
//   cfg     | in  | reg_index, wdata (pool_base, item_size, pool_count)
//
// allocate: the one-slot-a-cycle mark scan takes the first free slot it meets
//   and reports none free once it has passed every slot of the pool count
// free and index of address: the quotient comes from the 32-step divider
// address of index: a mark lookup; null or below-base rejects skip division
// reset clears all used marks at once, no sweep; cfg is always ready
// a finished beat sits in the response register, so the next request is
//   taken while the previous response still waits on rsp.ready; a second
//   finished beat holds in the result state until that register frees up
//
module fixed_block_pool_allocator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  fbpa_req_if.sink  req,
  fbpa_rsp_if.source rsp,
  fbpa_cfg_if.sink  cfg
);
  import fbpa_pkg::*;

  // raw register values as written
  logic [ADDR_W-1:0]      pool_base_q;
  logic [ITEM_W-1:0]      item_size_q;
  logic [CFG_COUNT_W-1:0] pool_count_q;

  logic [SIZE_W-1:0] size_sum;
  logic [SIZE_W-1:0] size_round;
  cfg_t              cfg_eff;
  req_t              req_pl;
  rsp_t              rsp_pl;
  div_cmd_t          div_cmd;
  div_res_t          div_res;

  // register writes land whenever the write beat completes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      item_size_q  <= ITEM_W'(ITEM_RESET);
      pool_count_q <= CFG_COUNT_W'(POOL_DEPTH);
    end else if (cfg.valid) begin
      case (cfg_idx_e'(cfg.reg_index))
        CFG_POOL_BASE:  pool_base_q  <= cfg.wdata[ADDR_W-1:0];
        CFG_ITEM_SIZE:  item_size_q  <= cfg.wdata[ITEM_W-1:0];
        CFG_POOL_COUNT: pool_count_q <= cfg.wdata[CFG_COUNT_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // block size rounded up to a multiple of four; zero size acts as four
  assign size_sum   = SIZE_W'(item_size_q) + SIZE_W'(3);
  assign size_round = {size_sum[SIZE_W-1:2], 2'b00};

  always_comb begin
    cfg_eff.base = pool_base_q;
    cfg_eff.size = (size_round == '0) ? SIZE_W'(4) : size_round;
    // slot count saturates at the pool depth
    if (32'(pool_count_q) > 32'(POOL_DEPTH)) begin
      cfg_eff.count = COUNT_W'(POOL_DEPTH);
    end else begin
      cfg_eff.count = COUNT_W'(pool_count_q);
    end
  end

  // request beat into the sequencer
  assign req_pl.req_type = req_e'(req.req_type);
  assign req_pl.address  = req.address;
  assign req_pl.index    = req.index;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .req_i       (req_pl),
    .cfg_i       (cfg_eff),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp_pl),
    .div_cmd_o   (div_cmd),
    .div_res_i   (div_res)
  );

  // shared divider: offset from base over block size
  fbpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  assign rsp.status        = rsp_pl.status;
  assign rsp.block_address = rsp_pl.block_address;
  assign rsp.block_index   = rsp_pl.block_index;

endmodule

// ===== rtl/fbpa_div.sv =====
// ----------------------------------------------------------------------------
// fbpa_div
// restoring divider, one quotient bit per cycle, offset over block size
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fbpa_pkg::div_cmd_t  cmd_i,
  output fbpa_pkg::div_res_t  res_o
);
  import fbpa_pkg::*;

  localparam int unsigned CNT_W = $clog2(ADDR_W);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] dvd_q, dvd_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] dvs_q, dvs_d;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              fits;

  assign trial = {rem_q, dvd_q[ADDR_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    if (cmd_i.start) begin
      active_d = 1'b1;
      cnt_d    = CNT_W'(ADDR_W - 1);
      dvd_d    = cmd_i.dividend;
      rem_d    = '0;
      dvs_d    = cmd_i.divisor;
    end else if (active_q) begin
      // shift next dividend bit in, quotient bit fills from the bottom
      rem_d = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      dvd_d = {dvd_q[ADDR_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dvd_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// request sequencer, used marks, slot scan and response register
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  fbpa_pkg::req_t      req_i,
  input  fbpa_pkg::cfg_t      cfg_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output fbpa_pkg::rsp_t      rsp_o,
  output fbpa_pkg::div_cmd_t  div_cmd_o,
  input  fbpa_pkg::div_res_t  div_res_i
);
  import fbpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_DIV    = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  req_e                type_q, type_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [COUNT_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic [SLOT_W-1:0]   search_q, search_d;
  logic [POOL_DEPTH-1:0] marks_q, marks_d;
  status_e             res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                rsp_valid_q, rsp_valid_d;
  rsp_t                rsp_q, rsp_d;

  logic                accept;
  logic                below;
  logic [ADDR_W-1:0]   offset;
  logic [SLOT_W-1:0]   start_slot;
  logic [SLOT_W-1:0]   rd_slot;
  logic                rd_mark;
  logic [COUNT_W-1:0]  slot_inc;
  logic                idx_beyond;
  logic                quot_beyond;
  logic [SLOT_W-1:0]   quot_slot;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   slot_addr;
  logic                with_addr;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign below       = req_i.address < cfg_i.base;
  assign offset      = req_i.address - cfg_i.base;
  assign start_slot  = ({1'b0, search_q} < cfg_i.count) ? search_q : '0;
  assign rd_slot     = (state_q == S_LOOKUP) ? SLOT_W'(idx_q) : slot_q;
  assign rd_mark     = marks_q[rd_slot];
  assign slot_inc    = COUNT_W'(slot_q) + COUNT_W'(1);
  assign idx_beyond  = 32'(idx_q) >= 32'(cfg_i.count);
  assign quot_beyond = div_res_i.quot >= ADDR_W'(cfg_i.count);
  assign quot_slot   = div_res_i.quot[SLOT_W-1:0];

  assign prod      = PROD_W'(res_slot_q) * PROD_W'(cfg_i.size);
  assign slot_addr = cfg_i.base + ADDR_W'(prod);
  assign with_addr = (res_status_q == ST_OK) &&
                     ((type_q == REQ_ALLOC) || (type_q == REQ_ADDR_OF_IX));

  assign div_cmd_o.start    = accept && (req_i.req_type == REQ_IX_OF_ADDR ||
                              (req_i.req_type == REQ_FREE && req_i.address != '0)) && !below;
  assign div_cmd_o.dividend = offset;
  assign div_cmd_o.divisor  = cfg_i.size;

  always_comb begin
    state_d      = state_q;
    type_d       = type_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    scan_cnt_d   = scan_cnt_q;
    search_d     = search_q;
    marks_d      = marks_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_d        = rsp_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          type_d     = req_i.req_type;
          idx_d      = req_i.index;
          res_slot_d = '0;
          case (req_i.req_type)
            REQ_ALLOC: begin
              slot_d     = start_slot;
              scan_cnt_d = '0;
              state_d    = S_SCAN;
            end
            REQ_FREE: begin
              if (req_i.address == '0) begin
                res_status_d = ST_NULL;
                state_d      = S_RESULT;
              end else if (below) begin
                res_status_d = ST_BELOW_BASE;
                state_d      = S_RESULT;
              end else begin
                state_d = S_DIV;
              end
            end
            REQ_ADDR_OF_IX: begin
              state_d = S_LOOKUP;
            end
            default: begin
              if (below) begin
                res_status_d = ST_BELOW_BASE;
                state_d      = S_RESULT;
              end else begin
                state_d = S_DIV;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // one slot a cycle, wrapping at the count
        if (scan_cnt_q == cfg_i.count) begin
          res_status_d = ST_NONE_FREE;
          state_d      = S_RESULT;
        end else if (!rd_mark) begin
          marks_d[slot_q] = 1'b1;
          search_d        = slot_q;
          res_status_d    = ST_OK;
          res_slot_d      = slot_q;
          state_d         = S_RESULT;
        end else begin
          slot_d     = (slot_inc == cfg_i.count) ? '0 : slot_inc[SLOT_W-1:0];
          scan_cnt_d = scan_cnt_q + COUNT_W'(1);
        end
      end
      S_LOOKUP: begin
        if (idx_beyond) begin
          res_status_d = ST_BEYOND_END;
        end else if (!rd_mark) begin
          res_status_d = ST_NOT_ALLOCATED;
        end else begin
          res_status_d = ST_OK;
          res_slot_d   = SLOT_W'(idx_q);
        end
        state_d = S_RESULT;
      end
      S_DIV: begin
        if (div_res_i.done) begin
          if (type_q == REQ_FREE && div_res_i.rem != '0) begin
            res_status_d = ST_MISALIGNED;
          end else if (quot_beyond) begin
            res_status_d = ST_BEYOND_END;
          end else begin
            res_status_d = ST_OK;
            res_slot_d   = quot_slot;
            if (type_q == REQ_FREE) begin
              marks_d[quot_slot] = 1'b0;
            end
          end
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d         = 1'b1;
          rsp_d.status        = res_status_q;
          rsp_d.block_address = with_addr ? slot_addr : '0;
          rsp_d.block_index   = (res_status_q == ST_OK) ? IDX_W'(res_slot_q) : '0;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      search_q    <= '0;
      marks_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      search_q    <= search_d;
      marks_q     <= marks_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q       <= type_d;
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    scan_cnt_q   <= scan_cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    rsp_q        <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
